>>> rtl/core/rqms_pkg.sv
// Package for the ready queue minimum-select block.
// Holds the transaction, entry and carry types and the operation and status codes.
// No dependencies.
package rqms_pkg;

  // Operation codes carried in the func field; code 7 has no meaning.
  typedef enum logic [2:0] {
    FUNC_APPEND     = 3'd0,
    FUNC_POP        = 3'd1,
    FUNC_PEEK       = 3'd2,
    FUNC_REMOVE_PID = 3'd3,
    FUNC_SHORTEST   = 3'd4,
    FUNC_BEST_PRIO  = 3'd5,
    FUNC_TAKE_LEAST = 3'd6
  } rqms_func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NONE = 2'd1,
    STATUS_FULL = 2'd2
  } rqms_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } rqms_state_t;

  // Width of a selection key: one bit above the 16-bit times for entries without a burst.
  localparam int KEY_W = 17;
  localparam logic [KEY_W-1:0] KEY_NO_BURST = 17'h10000;

  // Input transaction.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  entry_pid;
    logic [7:0]  entry_priority;
    logic [15:0] burst_length;
    logic [15:0] remaining_time;
    logic        is_ready;
    logic        has_burst;
    logic        burst_is_cpu;
  } rqms_in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_pid;
    logic [7:0]  out_priority;
    logic [15:0] out_burst;
    logic [15:0] out_remaining;
    logic [4:0]  occupancy;
  } rqms_out_t;

  // One stored queue entry.
  typedef struct packed {
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic        ready;
    logic        has_burst;
    logic        is_cpu;
  } rqms_entry_t;

  // Best-so-far record handed from cell to cell during a search.
  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [7:0]       pid;
    logic [7:0]       prio;
    logic [15:0]      burst;
    logic [15:0]      remaining;
  } rqms_carry_t;

  // Per-cell control from the controller.
  typedef struct packed {
    logic       valid;
    logic       load_new;
    logic       shift;
    logic [2:0] func;
    logic [7:0] match_pid;
  } rqms_cell_ctrl_t;

endpackage

>>> rtl/core/rqms_cell.sv
// One cell of the ready queue: holds a single entry and one stage of the search chain.
// Depends on rqms_pkg.
module rqms_cell import rqms_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic            clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  rqms_cell_ctrl_t ctrl,
  input  rqms_entry_t     new_entry,
  input  rqms_entry_t     next_entry,
  output rqms_entry_t     entry_out,
  input  rqms_carry_t     carry_in,
  input  logic [IDX_W-1:0] carry_idx_in,
  output rqms_carry_t     carry_out,
  output logic [IDX_W-1:0] carry_idx_out
);

  rqms_entry_t      entry_r;
  rqms_carry_t      carry_r;
  rqms_carry_t      carry_nxt;
  logic [IDX_W-1:0] carry_idx_r;
  logic [IDX_W-1:0] carry_idx_nxt;
  logic             candidate;
  logic             use_key;
  logic [KEY_W-1:0] key;
  logic             take;

  // Decide whether this entry qualifies and what key it is ranked by.
  always_comb begin
    candidate = 1'b0;
    use_key   = 1'b0;
    key       = '0;
    case (ctrl.func)
      FUNC_POP, FUNC_PEEK: begin
        candidate = 1'b1;
      end
      FUNC_REMOVE_PID: begin
        candidate = (entry_r.pid == ctrl.match_pid);
      end
      FUNC_SHORTEST: begin
        candidate = entry_r.ready && entry_r.has_burst && entry_r.is_cpu;
        use_key   = 1'b1;
        key       = {1'b0, entry_r.burst};
      end
      FUNC_BEST_PRIO: begin
        candidate = entry_r.ready && entry_r.has_burst && entry_r.is_cpu;
        use_key   = 1'b1;
        key       = {9'd0, entry_r.prio};
      end
      FUNC_TAKE_LEAST: begin
        candidate = 1'b1;
        use_key   = 1'b1;
        key       = entry_r.has_burst ? {1'b0, entry_r.remaining} : KEY_NO_BURST;
      end
      default: begin
        candidate = 1'b0;
      end
    endcase
  end

  // Take over the best-so-far record when this entry beats it; ties stay nearer the head.
  always_comb begin
    take = ctrl.valid && candidate &&
           (!carry_in.found || (use_key && (key < carry_in.key)));
    if (take) begin
      carry_nxt.found     = 1'b1;
      carry_nxt.key       = key;
      carry_nxt.pid       = entry_r.pid;
      carry_nxt.prio      = entry_r.prio;
      carry_nxt.burst     = entry_r.burst;
      carry_nxt.remaining = entry_r.remaining;
      carry_idx_nxt       = cell_idx;
    end else begin
      carry_nxt     = carry_in;
      carry_idx_nxt = carry_idx_in;
    end
  end

  // Search stage register.
  always_ff @(posedge clk) begin
    carry_r     <= carry_nxt;
    carry_idx_r <= carry_idx_nxt;
  end

  // Entry storage: load an appended entry or take the neighbour's entry on removal.
  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      entry_r <= new_entry;
    end else if (ctrl.shift) begin
      entry_r <= next_entry;
    end
  end

  assign entry_out     = entry_r;
  assign carry_out     = carry_r;
  assign carry_idx_out = carry_idx_r;

endmodule

>>> rtl/core/ready_queue_min_select.sv
// Top level of the ready queue minimum-select block: controller, result register and
// the row of queue cells. Depends on rqms_pkg and rqms_cell.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_data  (rqms_in_t)
//   out_     output     out_valid / out_stall out_data (rqms_out_t)
//
// Append and the unused operation code go from IDLE to COMMIT and back to IDLE.
// Every search-based operation passes through SCAN before COMMIT: the best-so-far record
// travels one cell per cycle along the row of QUEUE_DEPTH cells.
// Reset clears the controller state, the entry count and the result valid flag.
// A finished result waits in the output register; the next transaction is accepted
// meanwhile, and the block holds in its final cycle only while that register is full
// and the receiver stalls.
module ready_queue_min_select import rqms_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rqms_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rqms_out_t out_data
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SCAN_W = $clog2(QUEUE_DEPTH);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  rqms_state_t       state_r, state_nxt;
  logic [SCAN_W-1:0] scan_cnt_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  rqms_in_t          op_r;
  logic              out_valid_r;
  rqms_out_t         out_data_r, out_data_nxt;

  logic              accept;
  logic              out_free;
  logic              commit_fire;
  logic              do_remove;
  logic              do_append;
  logic [CNT_W+4:0]  occ_ext;

  rqms_entry_t       new_entry;
  rqms_entry_t       entries   [QUEUE_DEPTH];
  rqms_carry_t       carries   [QUEUE_DEPTH];
  logic [IDX_W-1:0]  carry_idxs[QUEUE_DEPTH];
  rqms_carry_t       last_carry;
  logic [IDX_W-1:0]  rem_idx;

  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign commit_fire = (state_r == S_COMMIT) && out_free;
  assign last_carry  = carries[QUEUE_DEPTH-1];
  assign rem_idx     = carry_idxs[QUEUE_DEPTH-1];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if ((in_data.func == FUNC_APPEND) || (in_data.func > FUNC_TAKE_LEAST)) begin
            state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == SCAN_LAST) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake outputs of the controller.
  always_comb begin
    in_stall = (state_r != S_IDLE);
  end

  // Result and queue update for the transaction being finished.
  always_comb begin
    out_data_nxt = '0;
    count_nxt    = count_r;
    do_remove    = 1'b0;
    do_append    = 1'b0;
    out_data_nxt.status = STATUS_NONE;
    case (op_r.func)
      FUNC_APPEND: begin
        if (count_r == CNT_FULL) begin
          out_data_nxt.status = STATUS_FULL;
        end else begin
          do_append                  = 1'b1;
          count_nxt                  = count_r + 1'b1;
          out_data_nxt.status        = STATUS_OK;
          out_data_nxt.out_pid       = op_r.entry_pid;
          out_data_nxt.out_priority  = op_r.entry_priority;
          out_data_nxt.out_burst     = op_r.burst_length;
          out_data_nxt.out_remaining = op_r.remaining_time;
        end
      end
      FUNC_POP, FUNC_REMOVE_PID, FUNC_TAKE_LEAST: begin
        if (last_carry.found) begin
          do_remove                  = 1'b1;
          count_nxt                  = count_r - 1'b1;
          out_data_nxt.status        = STATUS_OK;
          out_data_nxt.out_pid       = last_carry.pid;
          out_data_nxt.out_priority  = last_carry.prio;
          out_data_nxt.out_burst     = last_carry.burst;
          out_data_nxt.out_remaining = last_carry.remaining;
        end
      end
      FUNC_PEEK, FUNC_SHORTEST, FUNC_BEST_PRIO: begin
        if (last_carry.found) begin
          out_data_nxt.status        = STATUS_OK;
          out_data_nxt.out_pid       = last_carry.pid;
          out_data_nxt.out_priority  = last_carry.prio;
          out_data_nxt.out_burst     = last_carry.burst;
          out_data_nxt.out_remaining = last_carry.remaining;
        end
      end
      default: begin
        out_data_nxt.status = STATUS_NONE;
      end
    endcase
    occ_ext                = {5'd0, count_nxt};
    out_data_nxt.occupancy = occ_ext[4:0];
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= (state_r == S_SCAN) ? scan_cnt_r + 1'b1 : '0;
      if (commit_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Captured transaction and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_data;
    end
    if (commit_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry built from the captured append transaction.
  assign new_entry.pid       = op_r.entry_pid;
  assign new_entry.prio      = op_r.entry_priority;
  assign new_entry.burst     = op_r.burst_length;
  assign new_entry.remaining = op_r.remaining_time;
  assign new_entry.ready     = op_r.is_ready;
  assign new_entry.has_burst = op_r.has_burst;
  assign new_entry.is_cpu    = op_r.burst_is_cpu;

  // Row of queue cells, head at index zero.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rqms_cell_ctrl_t  ctrl;
    rqms_entry_t      next_entry;
    rqms_carry_t      carry_in;
    logic [IDX_W-1:0] carry_idx_in;

    assign ctrl.valid     = (CNT_W'(i) < count_r);
    assign ctrl.load_new  = commit_fire && do_append && (count_r == CNT_W'(i));
    assign ctrl.shift     = commit_fire && do_remove && (IDX_W'(i) >= rem_idx);
    assign ctrl.func      = op_r.func;
    assign ctrl.match_pid = op_r.entry_pid;

    if (i == 0) begin : g_first
      assign carry_in     = '0;
      assign carry_idx_in = '0;
    end else begin : g_rest
      assign carry_in     = carries[i-1];
      assign carry_idx_in = carry_idxs[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_body
      assign next_entry = entries[i+1];
    end

    rqms_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk          (clk),
      .cell_idx     (IDX_W'(i)),
      .ctrl         (ctrl),
      .new_entry    (new_entry),
      .next_entry   (next_entry),
      .entry_out    (entries[i]),
      .carry_in     (carry_in),
      .carry_idx_in (carry_idx_in),
      .carry_out    (carries[i]),
      .carry_idx_out(carry_idxs[i])
    );
  end

endmodule

>>> tb/rqms_checker.sv
// Result checker for the ready queue minimum-select block: keeps its own copy of the queue,
// predicts each result and compares it with what the block returns. Depends on rqms_pkg.
module rqms_checker import rqms_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  rqms_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  rqms_out_t out_data,
  output int        fail_count,
  output int        pending,
  output int        results_checked,
  output int        full_seen,
  output int        none_seen
);

  // One queued process entry as the checker holds it.
  typedef struct packed {
    logic [7:0]  pid;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic        ready;
    logic        has_burst;
    logic        is_cpu;
  } queue_slot_t;

  queue_slot_t queue_model [QUEUE_DEPTH];
  int          queue_len;
  rqms_out_t   expected_results [$];

  // Apply one transaction to the queue copy and return the result it should give.
  function automatic rqms_out_t apply_request(input rqms_in_t req);
    rqms_out_t        res;
    queue_slot_t      slot;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] best_key;
    logic             eligible;
    int               sel;
    int               i;
    res      = '0;
    sel      = -1;
    best_key = '0;
    slot     = '{req.entry_pid, req.entry_priority, req.burst_length, req.remaining_time,
                 req.is_ready, req.has_burst, req.burst_is_cpu};
    if (req.func == FUNC_APPEND) begin
      if (queue_len >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        queue_model[queue_len] = slot;
        queue_len++;
        sel = queue_len - 1;
      end
    end else if (queue_len == 0) begin
      res.status = STATUS_NONE;
    end else begin
      case (req.func)
        FUNC_POP, FUNC_PEEK: begin
          sel = 0;
        end
        FUNC_REMOVE_PID: begin
          for (i = 0; i < queue_len; i++) begin
            if (sel < 0 && queue_model[i].pid == req.entry_pid) sel = i;
          end
        end
        FUNC_SHORTEST, FUNC_BEST_PRIO: begin
          // Only ready entries with a pending CPU burst compete; strict less-than keeps
          // the entry nearest the head on a tie.
          for (i = 0; i < queue_len; i++) begin
            eligible = queue_model[i].ready && queue_model[i].has_burst &&
                       queue_model[i].is_cpu;
            key = (req.func == FUNC_SHORTEST) ? {1'b0, queue_model[i].burst}
                                              : {9'd0, queue_model[i].prio};
            if (eligible && (sel < 0 || key < best_key)) begin
              sel      = i;
              best_key = key;
            end
          end
        end
        FUNC_TAKE_LEAST: begin
          // An entry without a burst sorts above every real remaining time.
          for (i = 0; i < queue_len; i++) begin
            key = queue_model[i].has_burst ? {1'b0, queue_model[i].remaining} : KEY_NO_BURST;
            if (sel < 0 || key < best_key) begin
              sel      = i;
              best_key = key;
            end
          end
        end
        default: begin
          sel = -1;
        end
      endcase
      if (sel < 0) res.status = STATUS_NONE;
    end
    if (res.status == STATUS_OK) begin
      res.out_pid       = queue_model[sel].pid;
      res.out_priority  = queue_model[sel].prio;
      res.out_burst     = queue_model[sel].burst;
      res.out_remaining = queue_model[sel].remaining;
      // Pop, remove by pid and take-least close the gap behind the chosen entry.
      if (req.func == FUNC_POP || req.func == FUNC_REMOVE_PID ||
          req.func == FUNC_TAKE_LEAST) begin
        for (i = sel; i < queue_len - 1; i++) queue_model[i] = queue_model[i + 1];
        queue_len--;
      end
    end
    res.occupancy = 5'(queue_len);
    return res;
  endfunction

  // Compare one field and report a difference.
  function automatic void check_field(input string label, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want_v, got_v);
    end
  endfunction

  // Watch both channels at each rising edge. Results are matched before the new
  // transaction is predicted, since a transaction never returns in its own cycle.
  always @(posedge clk) begin
    rqms_out_t want;
    if (!rst_n) begin
      queue_len = 0;
      expected_results.delete();
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      full_seen       = 0;
      none_seen       = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("pid", 16'(want.out_pid), 16'(out_data.out_pid));
          check_field("priority", 16'(want.out_priority), 16'(out_data.out_priority));
          check_field("burst", want.out_burst, out_data.out_burst);
          check_field("remaining", want.out_remaining, out_data.out_remaining);
          check_field("occupancy", 16'(want.occupancy), 16'(out_data.occupancy));
          results_checked++;
          if (want.status == STATUS_FULL) full_seen++;
          if (want.status == STATUS_NONE) none_seen++;
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_data));
      pending = expected_results.size();
    end
  end

endmodule

>>> tb/tb_ready_queue_min_select.sv
// Testbench top for the ready queue minimum-select block: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on rqms_pkg, ready_queue_min_select and rqms_checker.
module tb_ready_queue_min_select;
  import rqms_pkg::*;

  localparam int         DEPTH         = 16;
  localparam logic [2:0] FUNC_UNUSED   = 3'd7;
  localparam int         TOTAL_ITEMS   = 1950;
  localparam int         LONG_HOLD     = 150;
  localparam int         SETTLE_CYCLES = 2 * DEPTH + 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rqms_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rqms_out_t out_data;

  int   fail_count;
  int   pending;
  int   results_checked;
  int   full_seen;
  int   none_seen;
  int   items_sent    = 0;
  int   burst_left    = 0;
  logic long_hold_req = 1'b0;

  always #1 clk = ~clk;

  ready_queue_min_select #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  rqms_checker #(.QUEUE_DEPTH(DEPTH)) result_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .full_seen      (full_seen),
    .none_seen      (none_seen)
  );

  // Build an append transaction.
  function automatic rqms_in_t append_req(input logic [7:0] pid, input logic [7:0] prio,
                                          input logic [15:0] burst, input logic [15:0] remain,
                                          input logic ready, input logic has_b,
                                          input logic cpu);
    rqms_in_t r;
    r = '{FUNC_APPEND, pid, prio, burst, remain, ready, has_b, cpu};
    return r;
  endfunction

  // Build a non-append transaction; the pid only matters for remove by pid.
  function automatic rqms_in_t op_req(input logic [2:0] func, input logic [7:0] pid);
    rqms_in_t r;
    r           = '0;
    r.func      = func;
    r.entry_pid = pid;
    return r;
  endfunction

  // Random transaction. Small pid and key ranges make matches and ties common; full
  // ranges now and then reach every bit.
  function automatic rqms_in_t random_req(input int append_pct);
    rqms_in_t r;
    int       roll;
    r.entry_pid      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 11));
    r.entry_priority = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 7));
    r.burst_length   = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 15));
    r.remaining_time = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 15));
    r.is_ready       = ($urandom_range(0, 3) != 0);
    r.has_burst      = ($urandom_range(0, 3) != 0);
    r.burst_is_cpu   = ($urandom_range(0, 3) != 0);
    roll = $urandom_range(0, 99);
    if (roll < append_pct) r.func = FUNC_APPEND;
    else if (roll >= 98) r.func = FUNC_UNUSED;
    else r.func = 3'($urandom_range(1, 6));
    return r;
  endfunction

  // Offer one transaction and hold it until accepted; at the end of a burst the
  // sender drops valid for a random gap.
  task automatic offer(input rqms_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 10);
      burst_left = $urandom_range(0, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Receiver: stretches of differing stall density, and one long hold-off on request.
  initial begin
    int stall_pct;
    int stretch;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stretch = $urandom_range(5, 40);
        repeat (stretch) begin
          @(posedge clk);
          out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int seg;
    int seg_len;
    int append_pct;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every search on an empty queue, and the unused code.
    offer(op_req(FUNC_POP, 8'd0));
    offer(op_req(FUNC_PEEK, 8'd0));
    offer(op_req(FUNC_REMOVE_PID, 8'd0));
    offer(op_req(FUNC_SHORTEST, 8'd0));
    offer(op_req(FUNC_BEST_PRIO, 8'd0));
    offer(op_req(FUNC_TAKE_LEAST, 8'd0));
    offer(op_req(FUNC_UNUSED, 8'd0));
    // A lone entry that is ready but not on a CPU burst, so nothing is eligible.
    offer(append_req(8'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    offer(op_req(FUNC_SHORTEST, 8'd0));
    offer(op_req(FUNC_BEST_PRIO, 8'd0));
    // No burst with zero remaining time, a tied pair under one pid, and an alternating pattern.
    offer(append_req(8'hFF, 8'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1));
    offer(append_req(8'd7, 8'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    offer(append_req(8'd7, 8'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    offer(append_req(8'hA5, 8'h5A, 16'h5A5A, 16'hA5A5, 1'b1, 1'b1, 1'b1));
    offer(op_req(FUNC_PEEK, 8'd0));
    offer(op_req(FUNC_SHORTEST, 8'd0));
    offer(op_req(FUNC_BEST_PRIO, 8'd0));
    offer(op_req(FUNC_REMOVE_PID, 8'd7));
    offer(op_req(FUNC_REMOVE_PID, 8'd99));
    offer(op_req(FUNC_TAKE_LEAST, 8'd0));
    offer(op_req(FUNC_TAKE_LEAST, 8'd0));
    offer(op_req(FUNC_POP, 8'd0));
    offer(op_req(FUNC_UNUSED, 8'd0));
    offer(op_req(FUNC_TAKE_LEAST, 8'd0));
    wait_drained();

    // Random segments that lean towards filling, draining or a mix; the first one
    // leans hardest towards filling, to push the queue towards its depth.
    seg = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       append_pct = 85;
        1:       append_pct = 25;
        default: append_pct = 50;
      endcase
      if (seg == 0) append_pct = 90;
      seg_len = $urandom_range(20, 80);
      if (seg == 3) long_hold_req = 1'b1;
      repeat (seg_len) offer(random_req(append_pct));
      if (seg == 8) wait_drained();
      seg++;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions in %0d segments; %0d results checked,", items_sent,
             seg, results_checked);
    $display("of which %0d hit a full queue and %0d found no entry.", full_seen, none_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** ready_queue_min_select: PASSED **");
    end else begin
      $display("** ready_queue_min_select: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("** ready_queue_min_select: FAILED **");
    $finish;
  end

endmodule
